>>> rtl/bb3_pkg.sv
// Shared types and constants of the 3x3 RGB box blur.
package bb3_pkg;

    localparam int MAX_SIDE_DEF     = 1024;
    localparam int CHANNEL_BITS_DEF = 16;
    localparam int RESQ_DEPTH_DEF   = 8;
    localparam int SIZE_W           = 11;
    localparam int CHAN_W           = 16;
    localparam int PADDR_W          = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd512;
    localparam logic REG_IMAGE_SIZE = 1'b0;
    localparam logic MODE_PIXEL     = 1'b0;
    localparam logic MODE_DRAIN     = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
    } item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              frame_end;
    } result_t;

    typedef struct packed {
        logic       adv;
        logic       is_pix;
        logic       emit;
        logic       n1;
        logic       kv0;
        logic       kv2;
        logic       rv0;
        logic       rv2;
        logic       done;
        logic [3:0] cnt;
    } ctl_t;

endpackage

>>> rtl/box_blur_3x3_rgb.sv
// Top level of the 3x3 RGB box blur.
// Pipeline: an accepted item passes the s1, s2 and s3 registers before its result is written into the result queue.
// Results lag the pixel stream by one row plus one pixel; drain items release the rest.
// Throughput: one item per cycle while the 8-entry result queue has room.
// Reset: counters, window and queue clear; line stores keep stale data; size reads 512.
module box_blur_3x3_rgb #(
    parameter int MAX_SIDE     = bb3_pkg::MAX_SIDE_DEF,
    parameter int CHANNEL_BITS = bb3_pkg::CHANNEL_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bb3_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  bb3_pkg::item_t              item,
    input  logic                        push,
    output logic                        full,
    output bb3_pkg::result_t            result,
    output logic                        empty,
    input  logic                        pop
);
    import bb3_pkg::*;

    localparam int SLOT_W = $clog2(MAX_SIDE);

    logic [SIZE_W-1:0] size_reg;
    logic              size_wr, pop_xfer, res_valid;
    ctl_t              ctl;
    logic [SLOT_W-1:0] slot;
    result_t           res;

    assign pready   = 1'b1;
    assign size_wr  = psel && penable && pwrite && (paddr[2] == REG_IMAGE_SIZE);
    assign prdata   = (paddr[2] == REG_IMAGE_SIZE) ? 32'(size_reg) : '0;
    assign pop_xfer = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= SIZE_RESET;
        else if (size_wr)
            size_reg <= pwdata[SIZE_W-1:0];
    end

    bb3_front #(.MAX_SIDE(MAX_SIDE), .RESQ_DEPTH(RESQ_DEPTH_DEF)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (size_wr),
        .image_size (size_reg),
        .push       (push),
        .mode       (item.mode),
        .pop_xfer   (pop_xfer),
        .full       (full),
        .ctl        (ctl),
        .slot       (slot)
    );

    bb3_back #(.MAX_SIDE(MAX_SIDE), .CHANNEL_BITS(CHANNEL_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (size_wr),
        .ctl        (ctl),
        .slot       (slot),
        .item       (item),
        .res_valid  (res_valid),
        .result     (res)
    );

    bb3_resq #(.DEPTH(RESQ_DEPTH_DEF)) u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_valid),
        .wdata (res),
        .rd    (pop_xfer),
        .rdata (result),
        .empty (empty)
    );

endmodule

>>> rtl/bb3_front.sv
// Front end: raster counters, item classification and result credit tracking.
module bb3_front #(
    parameter int MAX_SIDE   = bb3_pkg::MAX_SIDE_DEF,
    parameter int RESQ_DEPTH = bb3_pkg::RESQ_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  logic [bb3_pkg::SIZE_W-1:0]    image_size,
    input  logic                          push,
    input  logic                          mode,
    input  logic                          pop_xfer,
    output logic                          full,
    output bb3_pkg::ctl_t                 ctl,
    output logic [$clog2(MAX_SIDE)-1:0]   slot
);
    import bb3_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SIDE) + 2;
    localparam int SLOT_W = $clog2(MAX_SIDE);
    localparam int CR_W   = $clog2(RESQ_DEPTH + 1);

    logic [CNT_W-1:0] ir_reg, ic_reg, orow_reg, ocol_reg;
    logic [CNT_W-1:0] ir_next, ic_next, orow_next, ocol_next;
    logic             fr_reg, fr_next;
    logic [CR_W-1:0]  cr_reg, cr_next;
    logic [CNT_W-1:0] n;
    logic             acc, is_pix, n1, done;
    logic [1:0]       ck, cr_cnt;

    always_comb
    begin
        if (image_size == '0)
            n = CNT_W'(1);
        else if (32'(image_size) > MAX_SIDE)
            n = CNT_W'(MAX_SIDE);
        else
            n = CNT_W'(image_size);
    end

    assign full   = (cr_reg == CR_W'(RESQ_DEPTH));
    assign acc    = push && !full;
    assign is_pix = (mode == MODE_PIXEL);
    assign n1     = (mode == MODE_DRAIN) && (n == CNT_W'(1));
    assign slot   = ic_reg[SLOT_W-1:0];
    assign done   = (orow_reg == n - CNT_W'(1)) && (ocol_reg == n - CNT_W'(1));

    always_comb
    begin
        ctl.adv    = acc && ((is_pix && !fr_reg) || (!is_pix && fr_reg));
        ctl.is_pix = is_pix;
        ctl.n1     = n1;
        ctl.emit   = ctl.adv && (n1 || (ir_reg >= CNT_W'(2)) ||
                     ((ir_reg == CNT_W'(1)) && (ic_reg != '0)));
        ctl.kv0    = !n1 && (ocol_reg != '0);
        ctl.kv2    = !n1 && (ic_reg != '0) && (ocol_reg + CNT_W'(1) < n);
        ctl.rv0    = !n1 && (orow_reg != '0);
        ctl.rv2    = !n1 && (orow_reg + CNT_W'(1) < n);
        ctl.done   = done;
        ck         = 2'd1 + 2'(ctl.kv0) + 2'(ctl.kv2);
        cr_cnt     = 2'd1 + 2'(ctl.rv0) + 2'(ctl.rv2);
        ctl.cnt    = {2'b00, ck} * {2'b00, cr_cnt};
    end

    always_comb
    begin
        ir_next   = ir_reg;
        ic_next   = ic_reg;
        orow_next = orow_reg;
        ocol_next = ocol_reg;
        fr_next   = fr_reg;
        cr_next   = cr_reg + CR_W'(ctl.emit) - CR_W'(pop_xfer);
        if (restart)
        begin
            ir_next   = '0;
            ic_next   = '0;
            orow_next = '0;
            ocol_next = '0;
            fr_next   = 1'b0;
        end
        else if (ctl.adv)
        begin
            if (ctl.emit)
            begin
                ocol_next = ocol_reg + CNT_W'(1);
                if (ocol_next >= n)
                begin
                    ocol_next = '0;
                    orow_next = orow_reg + CNT_W'(1);
                end
            end
            ic_next = ic_reg + CNT_W'(1);
            if (ic_next >= n)
            begin
                ic_next = '0;
                ir_next = ir_reg + CNT_W'(1);
            end
            if (is_pix && (ir_reg == n - CNT_W'(1)) && (ic_reg == n - CNT_W'(1)))
                fr_next = 1'b1;
            if (ctl.emit && done)
            begin
                ir_next   = '0;
                ic_next   = '0;
                orow_next = '0;
                ocol_next = '0;
                fr_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_reg   <= '0;
            ic_reg   <= '0;
            orow_reg <= '0;
            ocol_reg <= '0;
            fr_reg   <= 1'b0;
            cr_reg   <= '0;
        end
        else
        begin
            ir_reg   <= ir_next;
            ic_reg   <= ic_next;
            orow_reg <= orow_next;
            ocol_reg <= ocol_next;
            fr_reg   <= fr_next;
            cr_reg   <= cr_next;
        end
    end

endmodule

>>> rtl/bb3_back.sv
// Back end: line stores, column window, masked sums and division by the count.
module bb3_back #(
    parameter int MAX_SIDE     = bb3_pkg::MAX_SIDE_DEF,
    parameter int CHANNEL_BITS = bb3_pkg::CHANNEL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  bb3_pkg::ctl_t                 ctl,
    input  logic [$clog2(MAX_SIDE)-1:0]   slot,
    input  bb3_pkg::item_t                item,
    output logic                          res_valid,
    output bb3_pkg::result_t              result
);
    import bb3_pkg::*;

    localparam int CB     = CHANNEL_BITS;
    localparam int SLOT_W = $clog2(MAX_SIDE);
    localparam int SUM_W  = CB + 4;
    localparam int K      = SUM_W;
    localparam int R_W    = K + 1;
    localparam int P_W    = SUM_W + R_W;
    localparam logic [R_W-1:0] R1 = R_W'((64'd1 << K) / 1);
    localparam logic [R_W-1:0] R2 = R_W'((64'd1 << K) / 2);
    localparam logic [R_W-1:0] R3 = R_W'((64'd1 << K) / 3);
    localparam logic [R_W-1:0] R4 = R_W'((64'd1 << K) / 4);
    localparam logic [R_W-1:0] R6 = R_W'((64'd1 << K) / 6);
    localparam logic [R_W-1:0] R9 = R_W'((64'd1 << K) / 9);

    logic [3*CB-1:0] older_mem [MAX_SIDE];
    logic [3*CB-1:0] newer_mem [MAX_SIDE];

    ctl_t                  s1_ctl_reg;
    logic [SLOT_W-1:0]     s1_slot_reg;
    logic [2:0][CB-1:0]    s1_px_reg;
    logic [2:0][CB-1:0]    rd_old_reg, rd_new_reg;
    logic [1:0][2:0][2:0][CB-1:0] win_reg;
    logic [2:0][2:0][CB-1:0] col;
    logic [2:0][SUM_W-1:0] sum;
    logic [2:0]            kmask, rmask;

    logic                  s2_v_reg, s2_done_reg;
    logic [3:0]            s2_cnt_reg;
    logic [2:0][SUM_W-1:0] s2_sum_reg;
    logic [R_W-1:0]        recip;

    logic                  s3_v_reg, s3_done_reg;
    logic [3:0]            s3_cnt_reg;
    logic [2:0][SUM_W-1:0] s3_sum_reg;
    logic [2:0][P_W-1:0]   s3_prod_reg;
    logic [2:0][CB-1:0]    quo;

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            rd_old_reg <= older_mem[slot];
            rd_new_reg <= newer_mem[slot];
        end
        if (s1_ctl_reg.adv && s1_ctl_reg.is_pix)
        begin
            older_mem[s1_slot_reg] <= rd_new_reg;
            newer_mem[s1_slot_reg] <= s1_px_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_ctl_reg <= '0;
        else
            s1_ctl_reg <= ctl;
    end

    always_ff @(posedge clk)
    begin
        s1_slot_reg  <= slot;
        s1_px_reg[0] <= ctl.is_pix ? item.in_red[CB-1:0]   : '0;
        s1_px_reg[1] <= ctl.is_pix ? item.in_green[CB-1:0] : '0;
        s1_px_reg[2] <= ctl.is_pix ? item.in_blue[CB-1:0]  : '0;
    end

    assign col[0] = rd_old_reg;
    assign col[1] = rd_new_reg;
    assign col[2] = s1_px_reg;
    assign kmask  = {s1_ctl_reg.kv2, 1'b1, s1_ctl_reg.kv0};
    assign rmask  = {s1_ctl_reg.rv2, 1'b1, s1_ctl_reg.rv0};

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum[c] = '0;
            // 1x1 image: the single pixel sits in the newest window column
            if (s1_ctl_reg.n1)
                sum[c] = SUM_W'(win_reg[1][2][c]);
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        if (kmask[k] && rmask[r])
                            sum[c] = sum[c] + SUM_W'((k < 2) ? win_reg[k][r][c] : col[r][c]);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (clear || (s1_ctl_reg.emit && s1_ctl_reg.done))
            win_reg <= '0;
        else if (s1_ctl_reg.adv)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s2_v_reg <= s1_ctl_reg.emit;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_comb
    begin
        case (s2_cnt_reg)
            4'd1:    recip = R1;
            4'd2:    recip = R2;
            4'd3:    recip = R3;
            4'd4:    recip = R4;
            4'd6:    recip = R6;
            4'd9:    recip = R9;
            default: recip = R1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        s2_sum_reg  <= sum;
        s2_cnt_reg  <= s1_ctl_reg.cnt;
        s2_done_reg <= s1_ctl_reg.done;
        for (int c = 0; c < 3; c++)
            s3_prod_reg[c] <= P_W'(s2_sum_reg[c]) * P_W'(recip);
        s3_sum_reg  <= s2_sum_reg;
        s3_cnt_reg  <= s2_cnt_reg;
        s3_done_reg <= s2_done_reg;
    end

    always_comb
    begin
        logic [SUM_W-1:0] q0, rem;
        for (int c = 0; c < 3; c++)
        begin
            q0  = SUM_W'(s3_prod_reg[c] >> K);
            rem = s3_sum_reg[c] - SUM_W'(q0 * SUM_W'(s3_cnt_reg));
            if (rem >= SUM_W'(s3_cnt_reg))
                q0 = q0 + SUM_W'(1);
            quo[c] = q0[CB-1:0];
        end
    end

    assign res_valid        = s3_v_reg;
    assign result.out_red   = CHAN_W'(quo[0]);
    assign result.out_green = CHAN_W'(quo[1]);
    assign result.out_blue  = CHAN_W'(quo[2]);
    assign result.frame_end = s3_done_reg;

endmodule

>>> rtl/bb3_resq.sv
// Result queue between the filter pipeline and the output side.
module bb3_resq #(
    parameter int DEPTH = bb3_pkg::RESQ_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  bb3_pkg::result_t  wdata,
    input  logic              rd,
    output bb3_pkg::result_t  rdata,
    output logic              empty
);
    import bb3_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t         q_reg [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [CW-1:0]   cnt_reg;

    assign empty = (cnt_reg == '0);
    assign rdata = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            q_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (rd)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + CW'(wr) - CW'(rd);
        end
    end

endmodule

>>> rtl/bb3_checker.sv
// Port-level checks for the box blur, bound to the top level.
module bb3_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [bb3_pkg::PADDR_W-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata,
    input logic                        pready,
    input bb3_pkg::item_t              item,
    input logic                        push,
    input logic                        full,
    input bb3_pkg::result_t            result,
    input logic                        empty,
    input logic                        pop
);
    logic acc;
    assign acc = push && !full;

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while waiting");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !acc ##1 !acc ##1 !acc ##1 (empty && !acc) |=> empty)
        else $error("result without an accepted item");

    a_full_needs_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (!full && !push) |=> !full)
        else $error("full rose without an input transfer");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (.*);

>>> tb/sv/tb.sv
// Testbench for box_blur_3x3_rgb: predicts each blurred pixel and checks the result stream.
`timescale 1ns / 100ps

module tb;
    import bb3_pkg::*;

    class blur_scoreboard;
        logic [CHAN_W-1:0] older_line[1024][3];
        logic [CHAN_W-1:0] newer_line[1024][3];
        logic [CHAN_W-1:0] win[2][3][3];
        int unsigned size_reg, in_row, in_col, out_row, out_col;
        bit frame_rx;
        result_t blurred_q[$];
        int errors;

        function new();
            size_reg = 32'(SIZE_RESET);
            errors = 0;
            restart();
        endfunction

        function void restart();
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            frame_rx = 0;
            foreach (win[k, r, c]) win[k][r][c] = '0;
        endfunction

        function void write_size(logic [31:0] v);
            size_reg = 32'(v[SIZE_W-1:0]);
            restart();
        endfunction

        function int unsigned side();
            if (size_reg == 0) return 1;
            if (size_reg > MAX_SIDE_DEF) return MAX_SIDE_DEF;
            return size_reg;
        endfunction

        function bit advance(bit is_pix, logic [CHAN_W-1:0] px[3]);
            int unsigned n, slot, cnt;
            int unsigned sum[3];
            logic [CHAN_W-1:0] col[3][3];
            bit emit, kv, rv, done, last_px;
            result_t r;
            n = side();
            slot = (in_col < MAX_SIDE_DEF) ? in_col : MAX_SIDE_DEF - 1;
            emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
            done = 0;
            last_px = 0;
            for (int c = 0; c < 3; c++)
            begin
                col[0][c] = older_line[slot][c];
                col[1][c] = newer_line[slot][c];
                col[2][c] = is_pix ? px[c] : '0;
            end
            if (emit)
            begin
                sum = '{0, 0, 0};
                cnt = 0;
                for (int k = 0; k < 3; k++)
                begin
                    kv = (k == 0) ? (out_col >= 1) : (k == 1) ? 1'b1
                         : (in_col != 0 && out_col + 1 < n);
                    if (!kv) continue;
                    for (int rr = 0; rr < 3; rr++)
                    begin
                        rv = (rr == 0) ? (out_row >= 1) : (rr == 1) ? 1'b1 : (out_row + 1 < n);
                        if (!rv) continue;
                        cnt++;
                        for (int c = 0; c < 3; c++)
                            sum[c] += (k < 2) ? win[k][rr][c] : col[rr][c];
                    end
                end
                done = (out_row == n - 1 && out_col == n - 1);
                r.out_red = CHAN_W'(sum[0] / cnt);
                r.out_green = CHAN_W'(sum[1] / cnt);
                r.out_blue = CHAN_W'(sum[2] / cnt);
                r.frame_end = done;
                blurred_q.push_back(r);
                out_col++;
                if (out_col >= n)
                begin
                    out_col = 0;
                    out_row++;
                end
            end
            win[0] = win[1];
            win[1] = col;
            if (is_pix)
            begin
                older_line[slot] = newer_line[slot];
                newer_line[slot] = px;
                last_px = (in_row == n - 1 && in_col == n - 1);
            end
            in_col++;
            if (in_col >= n)
            begin
                in_col = 0;
                in_row++;
            end
            if (last_px) frame_rx = 1;
            if (done) restart();
            return emit;
        endfunction

        function void note_item(item_t it);
            logic [CHAN_W-1:0] px[3];
            bit got;
            px[0] = it.in_red; px[1] = it.in_green; px[2] = it.in_blue;
            if (it.mode == MODE_PIXEL)
            begin
                if (!frame_rx) void'(advance(1, px));
            end
            else if (frame_rx)
            begin
                got = 0;
                while (!got && frame_rx) got = advance(0, px);
            end
        endfunction

        function void check_result(result_t act);
            result_t exp_r;
            if (blurred_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", act);
                return;
            end
            exp_r = blurred_q.pop_front();
            if (exp_r.out_red !== act.out_red || exp_r.out_green !== act.out_green ||
                exp_r.out_blue !== act.out_blue || exp_r.frame_end !== act.frame_end)
            begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p, got %p", exp_r, act);
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    item_t item;
    logic push, full;
    result_t result;
    logic empty, pop;
    bit quiet;
    int unsigned n_sent;
    blur_scoreboard sb;

    box_blur_3x3_rgb dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .item(item), .push(push), .full(full),
        .result(result), .empty(empty), .pop(pop)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    task automatic send(logic mode, logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                        logic [CHAN_W-1:0] blue);
        item_t it;
        it.mode = mode; it.in_red = red; it.in_green = green; it.in_blue = blue;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            push <= 0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        push <= 1;
        item <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_item(it);
        n_sent++;
    endtask

    task automatic send_pixel();
        send(MODE_PIXEL, rand_chan(), rand_chan(), rand_chan());
    endtask

    task automatic send_drain();
        send(MODE_DRAIN, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
    endtask

    task automatic wait_idle();
        push <= 0;
        @(posedge clk);
        while (sb.blurred_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_size(logic [31:0] v);
        wait_idle();
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {REG_IMAGE_SIZE, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.write_size(v);
    endtask

    // full frame; noisy adds early drains and dropped pixels after the last one, pause_mid waits midway
    task automatic run_frame(int unsigned sz, bit noisy, bit pause_mid);
        int unsigned n;
        n = (sz == 0) ? 1 : sz;
        write_size(sz);
        if (noisy) send_drain();
        for (int i = 0; i < n * n; i++)
        begin
            if (pause_mid && i == n * n / 2)
            begin
                push <= 0;
                @(posedge clk);
                while (sb.blurred_q.size() != 0) @(posedge clk);
            end
            send_pixel();
        end
        if (noisy) repeat ($urandom_range(1, 3)) send_pixel();
        while (sb.frame_rx) send_drain();
        if (noisy) send_drain();
    endtask

    initial
    begin
        int unsigned sz;
        sb = new();
        rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        item = '0; push = 0; pop = 0; quiet = 0; n_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        run_frame(0, 1, 0);
        run_frame(1, 1, 0);
        run_frame(2, 1, 0);
        run_frame(3, 0, 1);

        // oversize: short partial frame, then abandoned
        write_size(11'h7FF);
        repeat (20) send_pixel();
        write_size(1024);
        repeat (5) send_pixel();

        while (n_sent < 550)
        begin
            sz = $urandom_range(1, 8);
            if (n_sent > 450) quiet = 1;
            if ($urandom_range(0, 9) == 0)
            begin
                write_size(sz);
                repeat ($urandom_range(1, sz * sz)) send_pixel();
            end
            run_frame(sz, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
        end
        push <= 0;
        @(posedge clk);
        while (sb.blurred_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty) sb.check_result(result);
            if (stall > 0)
            begin
                stall--;
                pop <= 0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(0, 4);
                pop <= 0;
            end
            else
                pop <= 1;
        end
    end
endmodule
